@@ hdl/pkd_pkg.sv @@
// package for the packet deframer with checksum check
// holds phase and verdict codes, checksum constants and the byte residue function
// no dependencies
package pkd_pkg;

    localparam int SUM_BIAS = 3412;
    localparam int SUM_MOD  = 71;
    localparam int SUM_W    = 17;
    localparam int RES_W    = $clog2(SUM_MOD);
    localparam int BYTE_W   = 8;
    localparam int LEN_MIN  = 2;

    // residue of the bias, start value of every packet
    localparam logic [RES_W-1:0] BIAS_RES = RES_W'(SUM_BIAS % SUM_MOD);

    typedef enum logic [1:0] {
        PH_LEN = 2'd0,
        PH_CHK = 2'd1,
        PH_ID  = 2'd2,
        PH_PAY = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        VERDICT_BUSY  = 2'd0,
        VERDICT_GOOD  = 2'd1,
        VERDICT_BAD   = 2'd2,
        VERDICT_SHORT = 2'd3
    } t_verdict;

    // checksum unit results for one byte
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [RES_W-1:0]        res;
        logic                    good;
    } t_ck_out;

    // floor residue mod SUM_MOD of a byte taken as signed
    function automatic logic [RES_W-1:0] byte_mod(input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] t;
        // shift into a positive range below four moduli
        t = b[BYTE_W-1] ? ((BYTE_W+1)'(b) - (BYTE_W+1)'(256 - 2 * SUM_MOD))
                        : ((BYTE_W+1)'(b) + (BYTE_W+1)'(2 * SUM_MOD));
        if (t >= (BYTE_W+1)'(2 * SUM_MOD)) begin
            t = t - (BYTE_W+1)'(2 * SUM_MOD);
        end
        if (t >= (BYTE_W+1)'(SUM_MOD)) begin
            t = t - (BYTE_W+1)'(SUM_MOD);
        end
        return RES_W'(t);
    endfunction

endpackage

@@ hdl/pkd_in_stage.sv @@
// input register of the deframer, one item deep
// depends on pkd_pkg
module pkd_in_stage
    import pkd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_take,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              w_accept;

    // hold while the item in the register is not taken
    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

@@ hdl/pkd_cksum.sv @@
// running sum and mod-71 residue update with the checksum verdict
// depends on pkd_pkg
module pkd_cksum
    import pkd_pkg::*;
(
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic [RES_W-1:0]        i_res,
    input  logic [BYTE_W-1:0]       i_byte,
    input  logic                    i_add,
    input  logic [BYTE_W-1:0]       i_expected,
    output t_ck_out                 o_ck
);

    logic signed [SUM_W-1:0] w_sum;
    logic [RES_W:0]          w_res_sum;
    logic [RES_W-1:0]        w_res;
    logic signed [SUM_W:0]   w_total;
    logic                    w_neg;

    // signed accumulate of the byte
    assign w_sum = i_add ? (i_sum + SUM_W'($signed(i_byte))) : i_sum;

    // residue accumulate with one conditional subtract
    assign w_res_sum = {1'b0, i_res} + (i_add ? {1'b0, byte_mod(i_byte)} : '0);
    assign w_res = (w_res_sum >= (RES_W+1)'(SUM_MOD))
                 ? RES_W'(w_res_sum - (RES_W+1)'(SUM_MOD)) : RES_W'(w_res_sum);

    // sign of the biased total
    assign w_total = {w_sum[SUM_W-1], w_sum} + (SUM_W+1)'(SUM_BIAS);
    assign w_neg   = w_total[SUM_W];

    // truncated remainder of a negative total only matches when zero
    always_comb begin
        o_ck.sum = w_sum;
        o_ck.res = w_res;
        if (w_neg) begin
            o_ck.good = (w_res == '0) && (i_expected == '0);
        end else begin
            o_ck.good = ({{(BYTE_W-RES_W){1'b0}}, w_res} == i_expected);
        end
    end

endmodule

@@ hdl/pkd_frame.sv @@
// packet framing state machine, checksum state and result register
// depends on pkd_pkg and pkd_cksum
module pkd_frame
    import pkd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_take,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_is_packet_id,
    output logic              o_last,
    output t_verdict          o_verdict
);

    t_phase                  r_phase, n_phase;
    logic [BYTE_W-1:0]       r_left, n_left;
    logic [BYTE_W-1:0]       r_expected, n_expected;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [RES_W-1:0]        r_res, n_res;

    logic                    r_out_valid;
    logic [BYTE_W-1:0]       r_data_byte;
    logic                    r_is_id;
    logic                    r_last;
    t_verdict                r_verdict;

    logic                    w_emit;
    logic [BYTE_W-1:0]       w_data;
    logic                    w_is_id;
    logic                    w_last;
    t_verdict                w_verdict;
    logic                    w_add;
    logic                    w_out_free;
    t_ck_out                 w_ck;

    assign w_add = (r_phase == PH_PAY);

    pkd_cksum u_cksum (
        .i_sum      (r_sum),
        .i_res      (r_res),
        .i_byte     (i_byte),
        .i_add      (w_add),
        .i_expected (r_expected),
        .o_ck       (w_ck)
    );

    // an item moves on once the result register has room
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_take     = i_valid && w_out_free;

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_expected = r_expected;
        n_sum      = r_sum;
        n_res      = r_res;
        case (r_phase)
            PH_LEN: begin
                if (i_byte >= BYTE_W'(LEN_MIN)) begin
                    n_left  = i_byte - BYTE_W'(LEN_MIN);
                    n_sum   = '0;
                    n_res   = BIAS_RES;
                    n_phase = PH_CHK;
                end
            end
            PH_CHK: begin
                n_expected = i_byte;
                n_phase    = PH_ID;
            end
            PH_ID: begin
                n_phase = (r_left == '0) ? PH_LEN : PH_PAY;
            end
            PH_PAY: begin
                n_sum  = w_ck.sum;
                n_res  = w_ck.res;
                n_left = r_left - BYTE_W'(1);
                if (r_left == BYTE_W'(1)) begin
                    n_phase = PH_LEN;
                end
            end
            default: begin
                n_phase = PH_LEN;
            end
        endcase
    end

    // result fields
    always_comb begin
        w_emit    = 1'b0;
        w_data    = i_byte;
        w_is_id   = 1'b0;
        w_last    = 1'b0;
        w_verdict = VERDICT_BUSY;
        case (r_phase)
            PH_LEN: begin
                if (i_byte < BYTE_W'(LEN_MIN)) begin
                    w_emit    = 1'b1;
                    w_data    = '0;
                    w_last    = 1'b1;
                    w_verdict = VERDICT_SHORT;
                end
            end
            PH_CHK: begin
                w_emit = 1'b0;
            end
            PH_ID: begin
                w_emit  = 1'b1;
                w_is_id = 1'b1;
                if (r_left == '0) begin
                    w_last    = 1'b1;
                    w_verdict = w_ck.good ? VERDICT_GOOD : VERDICT_BAD;
                end
            end
            PH_PAY: begin
                w_emit = 1'b1;
                if (r_left == BYTE_W'(1)) begin
                    w_last    = 1'b1;
                    w_verdict = w_ck.good ? VERDICT_GOOD : VERDICT_BAD;
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // framing control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEN;
            r_left     <= '0;
            r_expected <= '0;
            r_sum      <= '0;
            r_res      <= BIAS_RES;
        end else if (o_take) begin
            r_phase    <= n_phase;
            r_left     <= n_left;
            r_expected <= n_expected;
            r_sum      <= n_sum;
            r_res      <= n_res;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_take && w_emit) begin
            r_data_byte <= w_data;
            r_is_id     <= w_is_id;
            r_last      <= w_last;
            r_verdict   <= w_verdict;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_byte    = r_data_byte;
    assign o_is_packet_id = r_is_id;
    assign o_last         = r_last;
    assign o_verdict      = r_verdict;

endmodule

@@ hdl/packet_deframer_checksum_core.sv @@
// top level of the packet deframer with checksum check
// depends on pkd_pkg, pkd_in_stage and pkd_frame
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-----------------------------------
//   rx       | in        | i_in_valid / o_in_stall | i_rx_byte
//   result   | out       | o_out_valid/ i_out_stall| o_data_byte, o_is_packet_id,
//            |           |                         | o_last, o_verdict
//
// one item per cycle sustained while the result side does not stall
// checksum bytes and lengths >= LEN_MIN give no result, every other byte exactly one
// a result passes through the input register and then the result register
// reset is synchronous, active low, and puts the framer back to waiting for a length
// a stalled result holds the result register; the input register then fills and stalls rx
module packet_deframer_checksum_core
    import pkd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_is_packet_id,
    output logic              o_last,
    output logic [1:0]        o_verdict
);

    logic              w_valid;
    logic [BYTE_W-1:0] w_byte;
    logic              w_take;
    t_verdict          w_verdict;

    // input register
    pkd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_byte  (i_rx_byte),
        .i_take  (w_take),
        .o_valid (w_valid),
        .o_byte  (w_byte)
    );

    // framing, checksum and result register
    pkd_frame u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_valid),
        .i_byte         (w_byte),
        .o_take         (w_take),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_data_byte    (o_data_byte),
        .o_is_packet_id (o_is_packet_id),
        .o_last         (o_last),
        .o_verdict      (w_verdict)
    );

    assign o_verdict = w_verdict;

endmodule
